[design/lr_pkg.sv]
// Shared types for the line rasterizer: command codes and direction flags.
// No dependencies; the classify, advance and top-level files refer to it by scoped names.
package lr_pkg;

	// Command carried by each request item.
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	// Octant of a line: which axis is major and which way each axis moves.
	typedef struct packed {
		logic major_is_y;
		logic x_down;
		logic y_down;
	} dir_t;

endpackage

[design/lr_req_if.sv]
// Request channel of the line rasterizer: valid/ready plus command and end points.
// Depends on nothing; width follows the COORD_BITS parameter.
interface lr_req_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [COORD_BITS-1:0] x_start;
	logic [COORD_BITS-1:0] y_start;
	logic [COORD_BITS-1:0] x_end;
	logic [COORD_BITS-1:0] y_end;

	modport source (output valid, cmd, x_start, y_start, x_end, y_end, input ready);
	modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, output ready);
endinterface

[design/lr_pix_if.sv]
// Pixel channel of the line rasterizer: valid/ready plus one pixel item.
// Depends on nothing; width follows the COORD_BITS parameter.
interface lr_pix_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  point_valid;
	logic                  last_point;

	modport source (output valid, pixel_x, pixel_y, point_valid, last_point, input ready);
	modport sink   (input valid, pixel_x, pixel_y, point_valid, last_point, output ready);
endinterface

[design/lr_classify.sv]
// Load path: octant classification and Bresenham setup terms for a new line.
// Depends on lr_pkg (dir_t).
module lr_classify #(
	parameter int COORD_BITS = 12
) (
	input  logic [COORD_BITS-1:0]        x_start,
	input  logic [COORD_BITS-1:0]        y_start,
	input  logic [COORD_BITS-1:0]        x_end,
	input  logic [COORD_BITS-1:0]        y_end,
	output lr_pkg::dir_t                 dir,
	output logic [COORD_BITS-1:0]        steps,
	output logic signed [COORD_BITS+1:0] decision,
	output logic signed [COORD_BITS+1:0] straight,
	output logic signed [COORD_BITS+1:0] diagonal,
	output logic                         active
);
	logic [COORD_BITS:0]   dx;
	logic [COORD_BITS:0]   dy;
	logic [COORD_BITS:0]   dx_neg;
	logic [COORD_BITS:0]   dy_neg;
	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic [COORD_BITS-1:0] major;
	logic [COORD_BITS-1:0] minor;

	// Signed deltas and their magnitudes; a magnitude always fits COORD_BITS.
	always_comb begin
		dx     = {1'b0, x_end} - {1'b0, x_start};
		dy     = {1'b0, y_end} - {1'b0, y_start};
		dx_neg = -dx;
		dy_neg = -dy;
		adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
	end

	// Pick the major axis; a tie goes to y.
	always_comb begin
		dir.major_is_y = (ady >= adx);
		dir.x_down     = dx[COORD_BITS];
		dir.y_down     = dy[COORD_BITS];
		major          = dir.major_is_y ? ady : adx;
		minor          = dir.major_is_y ? adx : ady;
	end

	// Decision term 2*minor - major and its two increments.
	always_comb begin
		straight = {1'b0, minor, 1'b0};
		decision = straight - {2'b00, major};
		diagonal = straight - {1'b0, major, 1'b0};
		steps    = major;
		active   = (major != '0);
	end
endmodule

[design/lr_advance.sv]
// Step path: one Bresenham iteration from the current line state.
// Depends on lr_pkg (dir_t).
module lr_advance #(
	parameter int COORD_BITS = 12
) (
	input  logic [COORD_BITS-1:0]        cur_x,
	input  logic [COORD_BITS-1:0]        cur_y,
	input  logic [COORD_BITS-1:0]        steps_left,
	input  logic signed [COORD_BITS+1:0] decision,
	input  logic signed [COORD_BITS+1:0] straight,
	input  logic signed [COORD_BITS+1:0] diagonal,
	input  lr_pkg::dir_t                 dir,
	output logic [COORD_BITS-1:0]        nxt_x,
	output logic [COORD_BITS-1:0]        nxt_y,
	output logic [COORD_BITS-1:0]        nxt_steps,
	output logic signed [COORD_BITS+1:0] nxt_decision,
	output logic                         last
);
	logic                  minor_moves;
	logic                  x_moves;
	logic                  y_moves;
	logic [COORD_BITS-1:0] x_moved;
	logic [COORD_BITS-1:0] y_moved;

	// The minor axis moves when the decision term is not negative.
	always_comb begin
		minor_moves = ~decision[COORD_BITS+1];
		x_moves     = dir.major_is_y ? minor_moves : 1'b1;
		y_moves     = dir.major_is_y ? 1'b1 : minor_moves;
		x_moved     = dir.x_down ? cur_x - 1'b1 : cur_x + 1'b1;
		y_moved     = dir.y_down ? cur_y - 1'b1 : cur_y + 1'b1;
		nxt_x       = x_moves ? x_moved : cur_x;
		nxt_y       = y_moves ? y_moved : cur_y;
	end

	// Update the decision term and the remaining pixel count.
	always_comb begin
		nxt_decision = decision + (minor_moves ? diagonal : straight);
		nxt_steps    = steps_left - 1'b1;
		last         = (steps_left == {{(COORD_BITS-1){1'b0}}, 1'b1});
	end
endmodule

[design/line_rasterizer.sv]
// Top level of the Bresenham line rasterizer: request register, line state, pixel register.
// Depends on lr_pkg, lr_req_if, lr_pix_if, lr_classify and lr_advance.
//
//   channel | modport | carries
//   --------+---------+-----------------------------------------------
//   req     | sink    | cmd, x_start, y_start, x_end, y_end
//   pix     | source  | pixel_x, pixel_y, point_valid, last_point
//
// A request item is registered, then handled from the request register: a load
// rewrites the line state, a step updates it and writes one pixel item.
// One item per cycle is sustained while pix is not stalled; the load setup (deltas,
// magnitude compare and the decision subtraction) is the longest path.
// Reset leaves no line active. A stalled pix holds its item; a step waits in
// the request register meanwhile, and loads still pass through.
module line_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input logic            clk,
	input logic            arst_n,
	lr_req_if.sink         req,
	lr_pix_if.source       pix
);
	// Request register.
	logic                  valid_s1;
	logic                  cmd_s1;
	logic [COORD_BITS-1:0] x_start_s1;
	logic [COORD_BITS-1:0] y_start_s1;
	logic [COORD_BITS-1:0] x_end_s1;
	logic [COORD_BITS-1:0] y_end_s1;

	// Line state.
	logic [COORD_BITS-1:0]        cur_x_q;
	logic [COORD_BITS-1:0]        cur_y_q;
	logic [COORD_BITS-1:0]        steps_q;
	logic signed [COORD_BITS+1:0] decision_q;
	logic signed [COORD_BITS+1:0] straight_q;
	logic signed [COORD_BITS+1:0] diagonal_q;
	lr_pkg::dir_t                 dir_q;
	logic                         active_q;

	// Pixel register.
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] pixel_x_q;
	logic [COORD_BITS-1:0] pixel_y_q;
	logic                  point_valid_q;
	logic                  last_point_q;

	// Load and step results.
	lr_pkg::dir_t                 ld_dir;
	logic [COORD_BITS-1:0]        ld_steps;
	logic signed [COORD_BITS+1:0] ld_decision;
	logic signed [COORD_BITS+1:0] ld_straight;
	logic signed [COORD_BITS+1:0] ld_diagonal;
	logic                         ld_active;
	logic [COORD_BITS-1:0]        st_x;
	logic [COORD_BITS-1:0]        st_y;
	logic [COORD_BITS-1:0]        st_steps;
	logic signed [COORD_BITS+1:0] st_decision;
	logic                         st_last;

	logic is_load;
	logic is_step;
	logic advance;

	lr_classify #(.COORD_BITS(COORD_BITS)) u_classify (
		.x_start  (x_start_s1),
		.y_start  (y_start_s1),
		.x_end    (x_end_s1),
		.y_end    (y_end_s1),
		.dir      (ld_dir),
		.steps    (ld_steps),
		.decision (ld_decision),
		.straight (ld_straight),
		.diagonal (ld_diagonal),
		.active   (ld_active)
	);

	lr_advance #(.COORD_BITS(COORD_BITS)) u_advance (
		.cur_x        (cur_x_q),
		.cur_y        (cur_y_q),
		.steps_left   (steps_q),
		.decision     (decision_q),
		.straight     (straight_q),
		.diagonal     (diagonal_q),
		.dir          (dir_q),
		.nxt_x        (st_x),
		.nxt_y        (st_y),
		.nxt_steps    (st_steps),
		.nxt_decision (st_decision),
		.last         (st_last)
	);

	// A load always completes; a step needs room in the pixel register.
	always_comb begin
		is_load   = valid_s1 && (cmd_s1 == lr_pkg::CMD_LOAD);
		is_step   = valid_s1 && (cmd_s1 == lr_pkg::CMD_STEP);
		advance   = is_load || (is_step && (!out_valid_q || pix.ready));
		req.ready = !valid_s1 || advance;
	end

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1     <= req.cmd;
			x_start_s1 <= req.x_start;
			y_start_s1 <= req.y_start;
			x_end_s1   <= req.x_end;
			y_end_s1   <= req.y_end;
		end
	end

	// Line state: rewritten by a load, advanced by a step on an active line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			steps_q    <= '0;
			decision_q <= '0;
			straight_q <= '0;
			diagonal_q <= '0;
			dir_q      <= '0;
			active_q   <= 1'b0;
		end else if (is_load) begin
			cur_x_q    <= x_start_s1;
			cur_y_q    <= y_start_s1;
			steps_q    <= ld_steps;
			decision_q <= ld_decision;
			straight_q <= ld_straight;
			diagonal_q <= ld_diagonal;
			dir_q      <= ld_dir;
			active_q   <= ld_active;
		end else if (advance && active_q) begin
			cur_x_q    <= st_x;
			cur_y_q    <= st_y;
			steps_q    <= st_steps;
			decision_q <= st_decision;
			active_q   <= (st_steps != '0);
		end
	end

	// Pixel register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_step) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Pixel register payload; a step with no active line reads as all zero.
	always_ff @(posedge clk) begin
		if (advance && is_step) begin
			pixel_x_q     <= active_q ? cur_x_q : '0;
			pixel_y_q     <= active_q ? cur_y_q : '0;
			point_valid_q <= active_q;
			last_point_q  <= active_q && st_last;
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_x     = pixel_x_q;
	assign pix.pixel_y     = pixel_y_q;
	assign pix.point_valid = point_valid_q;
	assign pix.last_point  = last_point_q;
endmodule

[design/lr_checker.sv]
// Port-level checks for the line rasterizer, attached to the top level by bind.
// Depends on line_rasterizer and the lr_req_if / lr_pix_if interfaces.
module lr_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pix_valid,
	input logic                  pix_ready,
	input logic [COORD_BITS-1:0] pixel_x,
	input logic [COORD_BITS-1:0] pixel_y,
	input logic                  point_valid,
	input logic                  last_point
);
	// A stalled pixel item stays offered.
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid)
		else $error("pixel item dropped while stalled");

	// A stalled pixel item keeps its payload.
	a_pix_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> $stable(pixel_x) && $stable(pixel_y)
			&& $stable(point_valid) && $stable(last_point))
		else $error("pixel payload changed while stalled");

	// An empty step result carries all-zero fields.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !point_valid |-> pixel_x == '0 && pixel_y == '0 && !last_point)
		else $error("empty step result carries nonzero fields");

	// The last-pixel mark appears only on a real pixel.
	a_last_real: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && last_point |-> point_valid)
		else $error("last pixel mark on an empty result");
endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_valid   (pix.valid),
	.pix_ready   (pix.ready),
	.pixel_x     (pix.pixel_x),
	.pixel_y     (pix.pixel_y),
	.point_valid (pix.point_valid),
	.last_point  (pix.last_point)
);

[sim/lr_tb_pkg.sv]
`timescale 1ns / 1ps
// Pixel predictor and scoreboard for the line rasterizer testbench.
// Depends on lr_pkg for the command codes and the octant flags.
package lr_tb_pkg;
	import lr_pkg::*;

	localparam int CW = 12;

	// One pixel item as it leaves the block.
	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          point_valid;
		logic          last_point;
	} pixel_item_t;

	class pixel_tracker;
		logic [CW-1:0]        cur_x, cur_y, steps_left;
		logic signed [CW+1:0] decision, inc_straight, inc_diag;
		dir_t                 dir;
		logic                 active;
		pixel_item_t          pending_pixels[$];
		int mismatches, loads, steps, checked, lines_done, idle_steps;

		function new();
			cur_x        = '0;
			cur_y        = '0;
			steps_left   = '0;
			decision     = '0;
			inc_straight = '0;
			inc_diag     = '0;
			dir          = '0;
			active       = 1'b0;
		endfunction

		function logic [CW-1:0] step_coord(logic [CW-1:0] c, logic down);
			return down ? c - 1'b1 : c + 1'b1;
		endfunction

		// Follows one accepted request item and queues the pixel a step produces.
		function void take_request(cmd_t cmd, logic [CW-1:0] xs, logic [CW-1:0] ys,
				logic [CW-1:0] xe, logic [CW-1:0] ye);
			logic signed [CW:0] dx, dy;
			logic [CW-1:0]      adx, ady, major, minor;
			logic               moves;
			pixel_item_t        pix;
			if (cmd == CMD_LOAD) begin
				loads++;
				dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
				dy = $signed({1'b0, ye}) - $signed({1'b0, ys});
				adx = dx[CW] ? -dx[CW-1:0] : dx[CW-1:0];
				ady = dy[CW] ? -dy[CW-1:0] : dy[CW-1:0];
				// Ties between the two magnitudes make y the major axis.
				dir.x_down     = dx[CW];
				dir.y_down     = dy[CW];
				dir.major_is_y = ady >= adx;
				major = dir.major_is_y ? ady : adx;
				minor = dir.major_is_y ? adx : ady;
				inc_straight = {1'b0, minor, 1'b0};
				inc_diag     = {1'b0, minor, 1'b0} - {1'b0, major, 1'b0};
				decision     = {1'b0, minor, 1'b0} - {2'b00, major};
				cur_x      = xs;
				cur_y      = ys;
				steps_left = major;
				active     = major != 0;
			end else begin
				steps++;
				if (!active) begin
					pix = '0;
				end else begin
					pix.x           = cur_x;
					pix.y           = cur_y;
					pix.point_valid = 1'b1;
					pix.last_point  = steps_left == 1;
					// The minor axis moves whenever the decision term is not negative.
					moves = !decision[CW+1];
					if (dir.major_is_y) begin
						cur_y = step_coord(cur_y, dir.y_down);
						if (moves) cur_x = step_coord(cur_x, dir.x_down);
					end else begin
						cur_x = step_coord(cur_x, dir.x_down);
						if (moves) cur_y = step_coord(cur_y, dir.y_down);
					end
					decision   = decision + (moves ? inc_diag : inc_straight);
					steps_left = steps_left - 1'b1;
					if (steps_left == 0) active = 1'b0;
				end
				pending_pixels.push_back(pix);
			end
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("%0t ns mismatch: %s", $time, what);
		endtask

		// Compares one accepted pixel item with the oldest one predicted.
		task check_pixel(pixel_item_t got);
			pixel_item_t want;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel item (%0d,%0d) arrived with none expected",
					got.x, got.y));
				return;
			end
			want = pending_pixels.pop_front();
			checked++;
			if (got.x !== want.x)
				report_mismatch($sformatf("pixel_x %0d, expected %0d", got.x, want.x));
			if (got.y !== want.y)
				report_mismatch($sformatf("pixel_y %0d, expected %0d", got.y, want.y));
			if (got.point_valid !== want.point_valid)
				report_mismatch($sformatf("point_valid %b, expected %b",
					got.point_valid, want.point_valid));
			if (got.last_point !== want.last_point)
				report_mismatch($sformatf("last_point %b, expected %b at (%0d,%0d)",
					got.last_point, want.last_point, want.x, want.y));
			if (want.last_point) lines_done++;
			if (!want.point_valid) idle_steps++;
		endtask
	endclass

endpackage

[sim/line_rasterizer_tb.sv]
`timescale 1ns / 1ps
// Testbench for line_rasterizer: random and directed lines in all octants, random gaps
// and stalls, every pixel checked against a predictor. Depends on lr_pkg, lr_tb_pkg, interfaces.
module line_rasterizer_tb;
	import lr_pkg::*;
	import lr_tb_pkg::*;

	localparam int MAXC = (1 << CW) - 1;

	logic clk = 1'b0;
	logic arst_n;
	int   items_sent = 0;
	bit   no_idle = 1'b0;

	pixel_tracker sb = new();

	lr_req_if #(.COORD_BITS(CW)) req_ch ();
	lr_pix_if #(.COORD_BITS(CW)) pix_ch ();

	line_rasterizer #(.COORD_BITS(CW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.pix    (pix_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Note every accepted request item in the predictor.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.take_request(cmd_t'(req_ch.cmd), req_ch.x_start, req_ch.y_start,
				req_ch.x_end, req_ch.y_end);
	end

	// Check every accepted pixel item.
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready)
			sb.check_pixel(pixel_item_t'{pix_ch.pixel_x, pix_ch.pixel_y,
				pix_ch.point_valid, pix_ch.last_point});
	end

	// The pixel side holds ready low for a random stall before each item.
	initial begin
		int stall;
		pix_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				pix_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_ch.ready <= 1'b1;
			do @(posedge clk); while (!pix_ch.valid);
		end
	end

	function automatic int mag(int v);
		return v < 0 ? -v : v;
	endfunction

	// Offers one request item after a random gap and waits until it is taken.
	task automatic send_item(cmd_t cmd, int xs, int ys, int xe, int ye);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.cmd     <= cmd;
		req_ch.x_start <= CW'(xs);
		req_ch.y_start <= CW'(ys);
		req_ch.x_end   <= CW'(xe);
		req_ch.y_end   <= CW'(ye);
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic send_step();
		send_item(CMD_STEP, $urandom_range(0, MAXC), $urandom_range(0, MAXC),
			$urandom_range(0, MAXC), $urandom_range(0, MAXC));
	endtask

	// Holds off the request side until every predicted pixel has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_pixels.size() != 0) @(posedge clk);
	endtask

	// Loads one random line, mostly short, and steps through it; some lines are
	// cut short by the next load and some are stepped past their end.
	task automatic run_line();
		int kind, span, xs, ys, xe, ye, d, major, pick, n;
		kind = $urandom_range(0, 99);
		span = (kind < 85) ? 12 : ((kind < 95) ? 64 : MAXC);
		xs = $urandom_range(0, MAXC);
		ys = $urandom_range(0, MAXC);
		xe = $urandom_range((xs > span) ? xs - span : 0, (xs + span > MAXC) ? MAXC : xs + span);
		ye = $urandom_range((ys > span) ? ys - span : 0, (ys + span > MAXC) ? MAXC : ys + span);
		if ($urandom_range(0, 19) == 0) begin
			xe = xs;
			ye = ys;
		end else if ($urandom_range(0, 6) == 0) begin
			// Equal magnitudes on both axes.
			d = mag(xe - xs);
			if (ys + d <= MAXC && (ys < d || $urandom_range(0, 1) == 1))
				ye = ys + d;
			else if (ys >= d)
				ye = ys - d;
		end
		major = (mag(xe - xs) > mag(ye - ys)) ? mag(xe - xs) : mag(ye - ys);
		send_item(CMD_LOAD, xs, ys, xe, ye);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			n = major;
		else if (pick < 85)
			n = major + $urandom_range(1, 3);
		else
			n = $urandom_range(0, major);
		if (n > 200) n = $urandom_range(1, 60);
		repeat (n) send_step();
	endtask

	initial begin
		int next_mode, next_drain;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.cmd     = CMD_LOAD;
		req_ch.x_start = '0;
		req_ch.y_start = '0;
		req_ch.x_end   = '0;
		req_ch.y_end   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Step with no line after reset.
		send_item(CMD_STEP, MAXC, MAXC, MAXC, MAXC);
		// Zero-length line leaves no line active.
		send_item(CMD_LOAD, 0, 0, 0, 0);
		send_item(CMD_STEP, 0, 0, 0, 0);
		// Leftward horizontal line at the top corner, stepped past its end.
		send_item(CMD_LOAD, MAXC, MAXC, MAXC - 3, MAXC);
		repeat (4) send_item(CMD_STEP, 0, 0, 0, 0);
		// Vertical line going toward y = 0.
		send_item(CMD_LOAD, 5, MAXC, 5, MAXC - 2);
		repeat (2) send_item(CMD_STEP, MAXC, MAXC, MAXC, MAXC);
		// Longest diagonal, replaced by a load while still active.
		send_item(CMD_LOAD, 0, 0, MAXC, MAXC);
		repeat (2) send_step();
		// Shallow line going right and down.
		send_item(CMD_LOAD, 10, 10, 13, 8);
		repeat (3) send_step();
		// Equal magnitudes, left and up.
		send_item(CMD_LOAD, MAXC, 0, MAXC - 2, 2);
		repeat (2) send_step();
		wait_drained();

		next_mode  = items_sent + 150;
		next_drain = items_sent + 400;
		while (items_sent < 1500) begin
			if (items_sent >= next_mode) begin
				no_idle   = $urandom_range(0, 3) == 0;
				next_mode = items_sent + 150;
			end
			if (items_sent >= next_drain) begin
				wait_drained();
				next_drain = items_sent + 400;
			end
			if ($urandom_range(0, 99) < 8)
				send_item(cmd_t'($urandom_range(0, 1)), $urandom_range(0, MAXC),
					$urandom_range(0, MAXC), $urandom_range(0, MAXC), $urandom_range(0, MAXC));
			else
				run_line();
		end
		wait_drained();
		repeat (12) @(posedge clk);

		$display("Ran %0d loads and %0d steps; %0d pixel items checked.",
			sb.loads, sb.steps, sb.checked);
		$display("%0d lines reached their last pixel, %0d steps found no line, %0d mismatches.",
			sb.lines_done, sb.idle_steps, sb.mismatches);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5_000_000;
		$display("Timed out with %0d pixel items outstanding.", sb.pending_pixels.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
